FILE: src/lsdrs_pkg.sv
`default_nettype none

package lsdrs_pkg;

  localparam int unsigned MaxItems  = 64;
  localparam int unsigned Radix     = 10;
  localparam int unsigned KeyW      = 31;
  localparam int unsigned AddrW     = $clog2(MaxItems);
  localparam int unsigned CntW      = $clog2(MaxItems + 1);
  localparam int unsigned DigitW    = $clog2(Radix);
  localparam int unsigned PassW     = 4;
  localparam int unsigned RecipW    = 32;
  localparam int unsigned ProdW     = KeyW + RecipW;
  localparam logic [RecipW-1:0] Recip10 = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            last;
  } in_t;

  typedef struct packed {
    logic [KeyW-1:0] sorted_key;
    logic            last_res;
    logic            overflow;
  } out_t;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [KeyW-1:0]   quo;
    logic [DigitW-1:0] digit;
  } entry_t;

  typedef enum logic [5:0] {
    S_LOAD    = 6'b000001,
    S_PLAN    = 6'b000010,
    S_COUNT   = 6'b000100,
    S_PREFIX  = 6'b001000,
    S_SCATTER = 6'b010000,
    S_OUT     = 6'b100000
  } state_e;

  function automatic logic [KeyW-1:0] pow10(input logic [PassW-1:0] k);
    logic [KeyW-1:0] p;
    case (k)
      4'd0:    p = 31'd1;
      4'd1:    p = 31'd10;
      4'd2:    p = 31'd100;
      4'd3:    p = 31'd1000;
      4'd4:    p = 31'd10000;
      4'd5:    p = 31'd100000;
      4'd6:    p = 31'd1000000;
      4'd7:    p = 31'd10000000;
      4'd8:    p = 31'd100000000;
      4'd9:    p = 31'd1000000000;
      default: p = 31'd1;
    endcase
    return p;
  endfunction

  function automatic logic [PassW-1:0] digit_count(input logic [KeyW-1:0] v);
    logic [PassW-1:0] c;
    c = '0;
    for (int k = 0; k < 10; k++) begin
      if (v >= pow10(PassW'(k))) begin
        c = c + 4'd1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/lsd_decimal_radix_sorter_top.sv
// Keys load one per cycle while busy_o is low; a key with last set starts the sort.
// After the last key the sort runs a count, prefix and scatter phase for each decimal
// digit of the largest key, then streams the sorted keys out.
// Results stream one per cycle, each strobed for one cycle; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the key set and returns to loading.
`default_nettype none

module lsd_decimal_radix_sorter_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire lsdrs_pkg::in_t in_i,
  output logic               res_valid_o,
  output lsdrs_pkg::out_t    res_o
);
  import lsdrs_pkg::*;

  state_e            state_q, state_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   n_q, n_d;
  logic [KeyW-1:0]   max_q, max_d;
  logic              drop_q, drop_d;
  logic              bank_q, bank_d;
  logic [PassW-1:0]  passes_q, passes_d;
  logic [PassW-1:0]  pass_q, pass_d;
  logic [DigitW-1:0] dig_q, dig_d;
  logic [CntW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   cnt_q [Radix];
  logic [CntW-1:0]   cnt_d [Radix];
  logic              v1_q, v1_d;
  logic              v2_q, v2_d;
  logic              res_valid_q, res_valid_d;
  out_t              res_q, res_d;

  logic [AddrW-1:0]  a1_q, a1_d;
  logic [AddrW-1:0]  a2_q;
  entry_t            e2_q;
  logic [ProdW-1:0]  prod_q;

  entry_t            mem0_q [MaxItems];
  entry_t            mem1_q [MaxItems];
  entry_t            rd0_q, rd1_q, rdata;
  logic [AddrW-1:0]  raddr, waddr;
  entry_t            wdata;
  logic              we0, we1;

  logic [KeyW-1:0]   quot, rem;
  logic [DigitW-1:0] digit;

  assign rdata = bank_q ? rd1_q : rd0_q;
  assign quot  = KeyW'(prod_q >> RecipShift);
  assign rem   = e2_q.quo - ((quot << 3) + (quot << 1));
  assign digit = rem[DigitW-1:0];

  assign busy_o      = (state_q != S_LOAD);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    logic [CntW-1:0] pos;
    pos         = '0;
    state_d     = state_q;
    idx_d       = idx_q;
    n_d         = n_q;
    max_d       = max_q;
    drop_d      = drop_q;
    bank_d      = bank_q;
    passes_d    = passes_q;
    pass_d      = pass_q;
    dig_d       = dig_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    v1_d        = 1'b0;
    a1_d        = idx_q[AddrW-1:0];
    v2_d        = 1'b0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    raddr       = idx_q[AddrW-1:0];
    waddr       = '0;
    wdata       = '0;
    we0         = 1'b0;
    we1         = 1'b0;

    case (state_q)
      S_LOAD: begin
        if (start_i) begin
          if (n_q < CntW'(MaxItems)) begin
            we0   = 1'b1;
            waddr = n_q[AddrW-1:0];
            wdata = '{key: in_i.key, quo: in_i.key, digit: '0};
            n_d   = n_q + 1'b1;
            if (in_i.key > max_q) begin
              max_d = in_i.key;
            end
          end else begin
            drop_d = 1'b1;
          end
          if (in_i.last) begin
            state_d = S_PLAN;
          end
        end
      end
      S_PLAN: begin
        passes_d = digit_count(max_q);
        pass_d   = '0;
        idx_d    = '0;
        for (int d = 0; d < Radix; d++) begin
          cnt_d[d] = '0;
        end
        state_d = (max_q == '0) ? S_OUT : S_COUNT;
      end
      S_COUNT: begin
        v2_d = v1_q;
        if (idx_q < n_q) begin
          idx_d = idx_q + 1'b1;
          v1_d  = 1'b1;
        end
        if (v2_q) begin
          we0          = ~bank_q;
          we1          = bank_q;
          waddr        = a2_q;
          wdata        = '{key: e2_q.key, quo: quot, digit: digit};
          cnt_d[digit] = cnt_q[digit] + 1'b1;
        end
        if (idx_q == n_q && !v1_q && !v2_q) begin
          dig_d   = '0;
          acc_d   = '0;
          state_d = S_PREFIX;
        end
      end
      S_PREFIX: begin
        cnt_d[dig_q] = acc_q;
        acc_d        = acc_q + cnt_q[dig_q];
        if (dig_q == DigitW'(Radix - 1)) begin
          idx_d   = '0;
          state_d = S_SCATTER;
        end else begin
          dig_d = dig_q + 1'b1;
        end
      end
      S_SCATTER: begin
        if (idx_q < n_q) begin
          idx_d = idx_q + 1'b1;
          v1_d  = 1'b1;
        end
        if (v1_q) begin
          pos                = cnt_q[rdata.digit];
          we0                = bank_q;
          we1                = ~bank_q;
          waddr              = pos[AddrW-1:0];
          wdata              = rdata;
          cnt_d[rdata.digit] = pos + 1'b1;
        end
        if (idx_q == n_q && !v1_q) begin
          bank_d = ~bank_q;
          pass_d = pass_q + 1'b1;
          idx_d  = '0;
          for (int d = 0; d < Radix; d++) begin
            cnt_d[d] = '0;
          end
          state_d = (pass_q + 1'b1 == passes_q) ? S_OUT : S_COUNT;
        end
      end
      S_OUT: begin
        if (idx_q < n_q) begin
          idx_d = idx_q + 1'b1;
          v1_d  = 1'b1;
        end
        if (v1_q) begin
          res_valid_d = 1'b1;
          res_d = '{sorted_key: rdata.key,
                    last_res:   ({1'b0, a1_q} == n_q - 1'b1),
                    overflow:   drop_q};
        end
        if (idx_q == n_q && !v1_q) begin
          n_d     = '0;
          max_d   = '0;
          drop_d  = 1'b0;
          bank_d  = 1'b0;
          idx_d   = '0;
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      idx_q       <= '0;
      n_q         <= '0;
      max_q       <= '0;
      drop_q      <= 1'b0;
      bank_q      <= 1'b0;
      passes_q    <= '0;
      pass_q      <= '0;
      dig_q       <= '0;
      acc_q       <= '0;
      for (int d = 0; d < Radix; d++) begin
        cnt_q[d] <= '0;
      end
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      max_q       <= max_d;
      drop_q      <= drop_d;
      bank_q      <= bank_d;
      passes_q    <= passes_d;
      pass_q      <= pass_d;
      dig_q       <= dig_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q   <= a1_d;
    a2_q   <= a1_q;
    e2_q   <= rdata;
    prod_q <= ProdW'(rdata.quo) * ProdW'(Recip10);
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0_q[waddr] <= wdata;
    end
    rd0_q <= mem0_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we1) begin
      mem1_q[waddr] <= wdata;
    end
    rd1_q <= mem1_q[raddr];
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lsdrs_pkg::*;

  localparam int unsigned MaxPasses   = 10;
  localparam int unsigned NumRows     = 19;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned CalmFirst   = 150;
  localparam int unsigned CalmLast    = 250;
  localparam int unsigned StallLimit  = 10000;
  localparam int unsigned DrainCycles = 1500;

  typedef struct packed {
    in_t  item;
    logic typed;
    out_t want;
  } step_row_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  in_t  in_i    = '0;
  logic busy_o;
  logic res_valid_o;
  out_t res_o;

  logic [KeyW-1:0] run_keys[$];
  logic [KeyW-1:0] run_peak    = '0;
  logic            run_dropped = 1'b0;
  out_t            sorted_due[$];
  int unsigned     errors      = 0;

  lsd_decimal_radix_sorter_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic step_row_t step_row(input logic [KeyW-1:0] k, input logic l,
                                         input logic t, input logic [KeyW-1:0] w);
    return {k, l, t, w, 1'b1, 1'b0};
  endfunction

  function automatic int unsigned digit_at(input logic [KeyW-1:0] v,
                                           input longint unsigned place);
    return int'((64'(v) / place) % Radix);
  endfunction

  function automatic logic [KeyW-1:0] draw_key(input logic [KeyW-1:0] prev);
    int unsigned span;
    span = 1;
    case ($urandom_range(9))
      0, 1, 2, 3: return KeyW'($urandom);
      4, 5, 6: begin
        repeat ($urandom_range(9, 1)) span = span * 10;
        return KeyW'($urandom_range(span - 1, 0));
      end
      7: return ($urandom_range(1) != 0) ? '1 : '0;
      default: return prev;
    endcase
  endfunction

  task automatic sort_run();
    logic [KeyW-1:0]   work  [MaxItems];
    logic [KeyW-1:0]   spill [MaxItems];
    int unsigned       tally [Radix];
    int unsigned       n;
    int unsigned       d;
    longint unsigned   place;
    longint unsigned   peak_wide;
    n         = run_keys.size();
    place     = 1;
    peak_wide = 64'(run_peak);
    for (int i = 0; i < n; i++) work[i] = run_keys[i];
    for (int p = 0; p < MaxPasses && (peak_wide / place) > 0; p++) begin
      for (int b = 0; b < Radix; b++) tally[b] = 0;
      for (int i = 0; i < n; i++) tally[digit_at(work[i], place)]++;
      for (int b = 1; b < Radix; b++) tally[b] += tally[b - 1];
      for (int i = n; i > 0; i--) begin
        d = digit_at(work[i - 1], place);
        tally[d]--;
        spill[tally[d]] = work[i - 1];
      end
      for (int i = 0; i < n; i++) work[i] = spill[i];
      place = place * Radix;
    end
    for (int i = 0; i < n; i++) begin
      sorted_due.push_back({work[i], (i == n - 1) ? 1'b1 : 1'b0, run_dropped});
    end
    run_keys.delete();
    run_peak    = '0;
    run_dropped = 1'b0;
  endtask

  task automatic collect_key(input in_t item);
    if (run_keys.size() < MaxItems) begin
      run_keys.push_back(item.key);
      if (item.key > run_peak) run_peak = item.key;
    end else begin
      run_dropped = 1'b1;
    end
    if (item.last) sort_run();
  endtask

  // enter and leave at a falling edge
  task automatic push_item(input in_t item, input bit calm);
    int unsigned gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < 26) gap++;
    end
    repeat (gap) begin
      start_i <= 1'b0;
      in_i    <= in_t'($urandom);
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= item;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check
    out_t want;
    if (rst_ni && res_valid_o) begin
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, res_o);
        errors++;
      end else begin
        want = sorted_due.pop_front();
        if (res_o.sorted_key !== want.sorted_key) begin
          $display("%0t: sorted_key mismatch, expected %0d, actual %0d",
                   $time, want.sorted_key, res_o.sorted_key);
          errors++;
        end
        if (res_o.last_res !== want.last_res) begin
          $display("%0t: last_res mismatch, expected %b, actual %b",
                   $time, want.last_res, res_o.last_res);
          errors++;
        end
        if (res_o.overflow !== want.overflow) begin
          $display("%0t: overflow mismatch, expected %b, actual %b",
                   $time, want.overflow, res_o.overflow);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((start_i && busy_o === 1'b0) || res_valid_o === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, StallLimit);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    step_row_t       plan [NumRows];
    in_t             item;
    logic [KeyW-1:0] prev;
    int unsigned     sent;
    int unsigned     runs;
    int unsigned     len;
    plan = '{
      step_row(31'd0,          1'b1, 1'b1, 31'd0),
      step_row(31'h7FFF_FFFF,  1'b1, 1'b1, 31'h7FFF_FFFF),
      step_row(31'd1,          1'b1, 1'b1, 31'd1),
      step_row(31'd0,          1'b0, 1'b0, 31'd0),
      step_row(31'd0,          1'b0, 1'b0, 31'd0),
      step_row(31'd0,          1'b1, 1'b0, 31'd0),
      step_row(31'd905,        1'b0, 1'b0, 31'd0),
      step_row(31'd15,         1'b0, 1'b0, 31'd0),
      step_row(31'd905,        1'b0, 1'b0, 31'd0),
      step_row(31'd1000000000, 1'b0, 1'b0, 31'd0),
      step_row(31'd0,          1'b0, 1'b0, 31'd0),
      step_row(31'h7FFF_FFFF,  1'b1, 1'b0, 31'd0),
      step_row(31'd9999,       1'b0, 1'b0, 31'd0),
      step_row(31'd999,        1'b0, 1'b0, 31'd0),
      step_row(31'd99,         1'b0, 1'b0, 31'd0),
      step_row(31'd9,          1'b1, 1'b0, 31'd0),
      step_row(31'h2AAA_AAAA,  1'b0, 1'b0, 31'd0),
      step_row(31'h5555_5555,  1'b1, 1'b0, 31'd0),
      step_row(31'd10,         1'b1, 1'b1, 31'd10)
    };
    prev = '0;
    sent = 0;
    runs = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // typed rows are single-key runs, so the predictor stays empty across them
    foreach (plan[r]) begin
      push_item(plan[r].item, 1'b0);
      if (plan[r].typed) sorted_due.push_back(plan[r].want);
      else collect_key(plan[r].item);
    end

    while (sent < RandomItems) begin
      case (runs)
        0:       len = MaxItems;
        1:       len = MaxItems + 1;
        2:       len = MaxItems + 6;
        default: len = ($urandom_range(9) == 0) ? $urandom_range(MaxItems + 8, MaxItems - 4)
                                                : $urandom_range(12, 1);
      endcase
      for (int k = 0; k < len; k++) begin
        item.key  = draw_key(prev);
        item.last = (k == len - 1);
        prev      = item.key;
        push_item(item, sent >= CalmFirst && sent < CalmLast);
        collect_key(item);
        sent++;
      end
      runs++;
    end
    start_i <= 1'b0;

    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lsdrs_pkg.sv
src/lsd_decimal_radix_sorter_top.sv
tb/tb_top.sv
